### rtl/core/keyed_slot_table_engine_macros.svh
// assertion macros for the keyed slot table engine
`ifndef KEYED_SLOT_TABLE_ENGINE_MACROS_SVH
`define KEYED_SLOT_TABLE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that holds at every clock edge out of reset
`define KSTE_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must be followed by another one on the next edge
`define KSTE_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KSTE_CHECK(lbl, prop, msg)
`define KSTE_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/kste_pkg.sv
`timescale 1ns / 1ps

package kste_pkg;

	// command codes
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_LIST   = 2'd1;
	localparam logic [1:0] MODE_FIND   = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	// result status codes
	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_ENTRY   = 3'd2;
	localparam logic [2:0] ST_NONE    = 3'd3;
	localparam logic [2:0] ST_REMOVED = 3'd4;
	localparam logic [2:0] ST_BADID   = 3'd5;

	// one stored record
	typedef struct packed {
		logic [63:0] first_key;
		logic [63:0] second_key;
		logic [63:0] value;
	} rec_t;

	// strobes from the sequencer to the slot store
	typedef struct packed {
		logic rd_en;
		logic vwr_en;
		logic vwr_bit;
		logic rwr_en;
	} store_ctl_t;

	// keep the top nb bytes and clear everything after the first zero byte
	function automatic logic [63:0] norm_text(input logic [63:0] s, input logic [3:0] nb);
		logic [63:0] r;
		logic        stop;
		logic [7:0]  ch;
		r    = '0;
		stop = 1'b0;
		for (int b = 0; b < 8; b++) begin
			ch = s[63 - 8 * b -: 8];
			if (4'(b) >= nb || ch == 8'd0) begin
				stop = 1'b1;
			end
			if (!stop) begin
				r[63 - 8 * b -: 8] = ch;
			end
		end
		return r;
	endfunction

endpackage

### rtl/core/kste_store.sv
`timescale 1ns / 1ps

module kste_store #(
	parameter int TABLE_DEPTH = 64,
	parameter int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                clk,
	input  kste_pkg::store_ctl_t ctl,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  kste_pkg::rec_t      wr_rec,
	output logic                rd_valid,
	output kste_pkg::rec_t      rd_rec
);
	import kste_pkg::*;

	// valid bits and records live in two separate arrays so remove touches one bit
	logic vld_mem [TABLE_DEPTH];
	rec_t rec_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.vwr_en) begin
			vld_mem[wr_addr] <= ctl.vwr_bit;
		end
		if (ctl.rwr_en) begin
			rec_mem[wr_addr] <= wr_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_valid <= vld_mem[rd_addr];
			rd_rec   <= rec_mem[rd_addr];
		end
	end

endmodule

### rtl/core/kste_ctrl.sv
`timescale 1ns / 1ps
`include "keyed_slot_table_engine_macros.svh"

module kste_ctrl #(
	parameter int TABLE_DEPTH = 64,
	parameter int TEXT_BYTES = 8,
	parameter int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [1:0]           mode,
	input  logic [63:0]          first_key,
	input  logic [63:0]          second_key,
	input  logic [63:0]          value_text,
	input  logic [6:0]           slot_id,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [2:0]           status,
	output logic [5:0]           entry_slot,
	output logic [63:0]          entry_first_key,
	output logic [63:0]          entry_second_key,
	output logic [63:0]          entry_value,
	output logic                 last,
	output kste_pkg::store_ctl_t ctl,
	output logic [AW-1:0]        rd_addr,
	output logic [AW-1:0]        wr_addr,
	output kste_pkg::rec_t       wr_rec,
	input  logic                 rd_valid,
	input  kste_pkg::rec_t       rd_rec
);
	import kste_pkg::*;

	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_FLUSH  = 3'd3;
	localparam logic [2:0] S_REMOVE = 3'd4;

	logic [2:0]    state_q, nxt_state;
	logic [AW-1:0] scan_q, nxt_scan;
	logic          issue_done_q, nxt_issue_done;
	logic          rd_s1, nxt_rd_s1;
	logic [AW-1:0] idx_s1, nxt_idx_s1;
	logic          pend_valid_q, nxt_pend_valid;
	logic [AW-1:0] pend_slot_q;
	rec_t          pend_rec_q;
	logic          pend_load;

	logic [1:0]    mode_q;
	logic [63:0]   key1_q, key2_q, val_q;
	logic [6:0]    id_q;

	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [5:0]    out_slot_q;
	rec_t          out_rec_q;
	logic          out_last_q;

	logic          push;
	logic [2:0]    push_status;
	logic [5:0]    push_slot;
	rec_t          push_rec;
	logic          push_last;

	logic          cmd_acc;
	logic          out_free;
	logic          is_add;
	logic          keys_eq;
	logic          hit;
	logic          need_out;
	logic          replay;
	logic          bad_id;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign out_free  = !out_valid_q || !res_stall;
	assign is_add    = (mode_q == MODE_ADD);
	assign keys_eq   = (rd_rec.first_key == key1_q) && (rd_rec.second_key == key2_q);
	assign hit       = is_add ? !rd_valid
		: (rd_valid && (mode_q == MODE_LIST || (mode_q == MODE_FIND && keys_eq)));
	assign need_out  = rd_s1 && hit && (is_add || pend_valid_q);
	// a slot that cannot be delivered now is read again
	assign replay    = need_out && !out_free;
	assign bad_id    = 32'(id_q) >= 32'(TABLE_DEPTH);

	always_comb begin
		nxt_state      = state_q;
		nxt_scan       = scan_q;
		nxt_issue_done = issue_done_q;
		nxt_rd_s1      = 1'b0;
		nxt_idx_s1     = idx_s1;
		nxt_pend_valid = pend_valid_q;
		pend_load      = 1'b0;
		ctl            = '0;
		rd_addr        = scan_q;
		wr_addr        = idx_s1;
		wr_rec         = '{first_key: key1_q, second_key: key2_q, value: val_q};
		push           = 1'b0;
		push_status    = ST_NONE;
		push_slot      = '0;
		push_rec       = '0;
		push_last      = 1'b1;
		case (state_q)
			S_CLEAR: begin
				ctl.vwr_en = 1'b1;
				wr_addr    = scan_q;
				nxt_scan   = scan_q + 1'b1;
				if (scan_q == LAST_IDX) begin
					nxt_scan  = '0;
					nxt_state = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_acc) begin
					nxt_scan       = '0;
					nxt_issue_done = 1'b0;
					nxt_state      = (mode == MODE_REMOVE) ? S_REMOVE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (!issue_done_q) begin
					ctl.rd_en  = 1'b1;
					nxt_rd_s1  = 1'b1;
					nxt_idx_s1 = scan_q;
					nxt_scan   = scan_q + 1'b1;
					if (scan_q == LAST_IDX) begin
						nxt_issue_done = 1'b1;
					end
				end
				if (rd_s1) begin
					if (replay) begin
						nxt_scan       = idx_s1;
						nxt_issue_done = 1'b0;
						nxt_rd_s1      = 1'b0;
					end else if (hit && is_add) begin
						ctl.vwr_en  = 1'b1;
						ctl.vwr_bit = 1'b1;
						ctl.rwr_en  = 1'b1;
						push        = 1'b1;
						push_status = ST_ADDED;
						push_slot   = 6'(idx_s1);
						nxt_rd_s1   = 1'b0;
						nxt_state   = S_IDLE;
					end else begin
						if (hit) begin
							if (pend_valid_q) begin
								push        = 1'b1;
								push_status = ST_ENTRY;
								push_slot   = 6'(pend_slot_q);
								push_rec    = pend_rec_q;
								push_last   = 1'b0;
							end
							nxt_pend_valid = 1'b1;
							pend_load      = 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							nxt_rd_s1 = 1'b0;
							nxt_state = S_FLUSH;
						end
					end
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					push = 1'b1;
					if (is_add) begin
						push_status = ST_FULL;
					end else if (pend_valid_q) begin
						push_status = ST_ENTRY;
						push_slot   = 6'(pend_slot_q);
						push_rec    = pend_rec_q;
					end
					nxt_pend_valid = 1'b0;
					nxt_state      = S_IDLE;
				end
			end
			S_REMOVE: begin
				if (out_free) begin
					push = 1'b1;
					if (bad_id) begin
						push_status = ST_BADID;
					end else begin
						ctl.vwr_en  = 1'b1;
						wr_addr     = AW'(id_q);
						push_status = ST_REMOVED;
					end
					nxt_state = S_IDLE;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			scan_q       <= '0;
			issue_done_q <= 1'b0;
			rd_s1        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= nxt_state;
			scan_q       <= nxt_scan;
			issue_done_q <= nxt_issue_done;
			rd_s1        <= nxt_rd_s1;
			pend_valid_q <= nxt_pend_valid;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= nxt_idx_s1;
		if (cmd_acc) begin
			mode_q <= mode;
			key1_q <= norm_text(first_key, 4'(TEXT_BYTES));
			key2_q <= norm_text(second_key, 4'(TEXT_BYTES));
			val_q  <= norm_text(value_text, 4'(TEXT_BYTES));
			id_q   <= slot_id;
		end
		if (pend_load) begin
			pend_slot_q <= idx_s1;
			pend_rec_q  <= rd_rec;
		end
		if (push) begin
			out_status_q <= push_status;
			out_slot_q   <= push_slot;
			out_rec_q    <= push_rec;
			out_last_q   <= push_last;
		end
	end

	assign res_valid        = out_valid_q;
	assign status           = out_status_q;
	assign entry_slot       = out_slot_q;
	assign entry_first_key  = out_rec_q.first_key;
	assign entry_second_key = out_rec_q.second_key;
	assign entry_value      = out_rec_q.value;
	assign last             = out_last_q;

	`KSTE_CHECK(a_rd_in_scan, rd_s1 |-> state_q == S_SCAN, "read data outside a scan")
	`KSTE_CHECK(a_pend_in_run, pend_valid_q |-> (state_q == S_SCAN || state_q == S_FLUSH), "pending entry left over")
	`KSTE_CHECK_NEXT(a_cmd_starts, cmd_valid && !cmd_stall, state_q == S_SCAN || state_q == S_REMOVE, "request did not start")
	`KSTE_CHECK(a_only_entry_open, (res_valid && !last) |-> status == ST_ENTRY, "open run on non-entry result")
	`KSTE_CHECK(a_no_idle_write, ctl.vwr_en |-> (state_q != S_IDLE && state_q != S_FLUSH), "valid write while not busy")

endmodule

### rtl/core/keyed_slot_table_engine.sv
// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------------------
// request   | cmd_valid / cmd_stall  | mode, first_key, second_key, value_text, slot_id
// result    | res_valid / res_stall  | status, entry_slot, entry_first_key,
//           |                        | entry_second_key, entry_value, last
//
// one request at a time; the slot store is walked one entry per cycle on its read port
// unless a result stall forces a re-read; list and find walk every slot, add stops at
// the first free slot (every slot when full), remove walks no slots
// after reset the valid bits are cleared in a pass over all TABLE_DEPTH slots, cmd_stall high
// a result stall that blocks a found entry costs a re-read of that slot
`timescale 1ns / 1ps

module keyed_slot_table_engine #(
	parameter int TABLE_DEPTH = 64,
	parameter int TEXT_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] first_key,
	input  logic [63:0] second_key,
	input  logic [63:0] value_text,
	input  logic [6:0]  slot_id,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic [5:0]  entry_slot,
	output logic [63:0] entry_first_key,
	output logic [63:0] entry_second_key,
	output logic [63:0] entry_value,
	output logic        last
);
	import kste_pkg::*;

	// address width of the slot store
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	store_ctl_t    ctl;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	rec_t          wr_rec;
	logic          rd_valid;
	rec_t          rd_rec;

	// sequencer: command decode, slot walk, pending entry for the last mark,
	// result register
	kste_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.TEXT_BYTES (TEXT_BYTES),
		.AW         (AW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.mode            (mode),
		.first_key       (first_key),
		.second_key      (second_key),
		.value_text      (value_text),
		.slot_id         (slot_id),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.status          (status),
		.entry_slot      (entry_slot),
		.entry_first_key (entry_first_key),
		.entry_second_key(entry_second_key),
		.entry_value     (entry_value),
		.last            (last),
		.ctl             (ctl),
		.rd_addr         (rd_addr),
		.wr_addr         (wr_addr),
		.wr_rec          (wr_rec),
		.rd_valid        (rd_valid),
		.rd_rec          (rd_rec)
	);

	// slot store: valid bits and records, one read and one write per cycle,
	// registered read data; writes come from the reset clear pass, an add and a remove
	kste_store #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_rec  (wr_rec),
		.rd_valid(rd_valid),
		.rd_rec  (rd_rec)
	);

endmodule
